// File: hw/rtl/lr_pkg.sv
package lr_pkg;

  localparam int DIM_BITS = 13;
  localparam int REG_INDEX_BITS = 1;

  typedef enum logic {
    CMD_START = 1'b0,
    CMD_STEP  = 1'b1
  } cmd_t;

  typedef enum logic [REG_INDEX_BITS-1:0] {
    REG_CANVAS_WIDTH  = 1'b0,
    REG_CANVAS_HEIGHT = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic emit;
    logic on_canvas;
    logic last_pixel;
  } pixel_flags_t;

endpackage

// File: hw/rtl/lr_engine.sv
module lr_engine #(
  parameter int COORD_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          go,
  input  lr_pkg::cmd_t                  cmd,
  input  logic signed [COORD_BITS-1:0]  start_x,
  input  logic signed [COORD_BITS-1:0]  start_y,
  input  logic signed [COORD_BITS-1:0]  end_x,
  input  logic signed [COORD_BITS-1:0]  end_y,
  input  logic [lr_pkg::DIM_BITS-1:0]   canvas_width,
  input  logic [lr_pkg::DIM_BITS-1:0]   canvas_height,
  output logic signed [COORD_BITS-1:0]  pixel_x,
  output logic signed [COORD_BITS-1:0]  pixel_y,
  output lr_pkg::pixel_flags_t          flags
);
  import lr_pkg::*;

  localparam int C = COORD_BITS;
  localparam int E = COORD_BITS + 3;
  localparam int CMP_BITS = (COORD_BITS > DIM_BITS) ? COORD_BITS : DIM_BITS;

  logic signed [C-1:0] cur_x, cur_y, goal_x, goal_y;
  logic [C-1:0] delta_major, delta_minor;
  logic signed [E-1:0] error_term;
  logic x_step_neg, y_step_neg, steep_flag, line_active;

  // start: deltas, direction and initial decision term
  logic signed [C:0] diff_x, diff_y;
  logic [C:0] abs_x, abs_y;
  logic [C-1:0] dx, dy, major_init, minor_init;
  logic steep_init;
  logic signed [E-1:0] error_init;

  always_comb begin
    diff_x = $signed({end_x[C-1], end_x}) - $signed({start_x[C-1], start_x});
    diff_y = $signed({end_y[C-1], end_y}) - $signed({start_y[C-1], start_y});
    abs_x = diff_x[C] ? -diff_x : diff_x;
    abs_y = diff_y[C] ? -diff_y : diff_y;
    dx = abs_x[C-1:0];
    dy = abs_y[C-1:0];
    steep_init = dy > dx;
    major_init = steep_init ? dy : dx;
    minor_init = steep_init ? dx : dy;
    error_init = $signed({{(E-C-1){1'b0}}, minor_init, 1'b0})
               - $signed({{(E-C){1'b0}}, major_init});
  end

  // step: current pixel, flags and the next position
  logic on_x, on_y, last, minor_move;
  logic signed [C-1:0] x_adv, y_adv, x_next, y_next;
  logic signed [E-1:0] err_minus, error_next;

  always_comb begin
    on_x = !cur_x[C-1] &&
           ({{(CMP_BITS-C){1'b0}}, cur_x} < {{(CMP_BITS-DIM_BITS){1'b0}}, canvas_width});
    on_y = !cur_y[C-1] &&
           ({{(CMP_BITS-C){1'b0}}, cur_y} < {{(CMP_BITS-DIM_BITS){1'b0}}, canvas_height});
    last = steep_flag ? (cur_y == goal_y) : (cur_x == goal_x);
    minor_move = !error_term[E-1] && (error_term != '0);
    x_adv = x_step_neg ? cur_x - C'(1) : cur_x + C'(1);
    y_adv = y_step_neg ? cur_y - C'(1) : cur_y + C'(1);
    x_next = (!steep_flag || minor_move) ? x_adv : cur_x;
    y_next = (steep_flag || minor_move) ? y_adv : cur_y;
    err_minus = minor_move ? $signed({{(E-C-1){1'b0}}, delta_major, 1'b0}) : '0;
    error_next = error_term - err_minus + $signed({{(E-C-1){1'b0}}, delta_minor, 1'b0});
    pixel_x = cur_x;
    pixel_y = cur_y;
    flags.emit = (cmd == CMD_STEP) && line_active;
    flags.on_canvas = on_x && on_y;
    flags.last_pixel = last;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x <= '0;
      cur_y <= '0;
      goal_x <= '0;
      goal_y <= '0;
      delta_major <= '0;
      delta_minor <= '0;
      error_term <= '0;
      x_step_neg <= 1'b0;
      y_step_neg <= 1'b0;
      steep_flag <= 1'b0;
      line_active <= 1'b0;
    end else if (go) begin
      if (cmd == CMD_START) begin
        cur_x <= start_x;
        cur_y <= start_y;
        goal_x <= end_x;
        goal_y <= end_y;
        delta_major <= major_init;
        delta_minor <= minor_init;
        error_term <= error_init;
        x_step_neg <= diff_x[C];
        y_step_neg <= diff_y[C];
        steep_flag <= steep_init;
        line_active <= 1'b1;
      end else if (line_active) begin
        if (last) begin
          line_active <= 1'b0;
        end else begin
          cur_x <= x_next;
          cur_y <= y_next;
          error_term <= error_next;
        end
      end
    end
  end

endmodule

// File: hw/rtl/line_rasterizer_core.sv
// line rasterizer core
//
// input channel (in_valid / in_stall): one command per transfer. a start
// command (command = 0) loads start_x/start_y and end_x/end_y and gives no
// pixel. each step command (command = 1) gives the next pixel of the line,
// from the first endpoint to the second; a step with no line in progress
// is dropped.
// output channel (out_valid / out_stall): pixel_x, pixel_y, on_canvas and
// last_pixel, which marks the pixel at the second endpoint.
// config port: cfg_wr_en with cfg_index 0 writes the canvas width, index 1
// the canvas height; write only while no command is in flight.
// a step transferred on the input lands in the input register and shows
// its pixel on the output when the result register loads. throughput is
// one command per cycle while out_stall is low.
// reset: no line in progress, canvas 800 by 800, both channels empty.
// while out_stall holds, the result register holds its pixel and the input
// register fills; in_stall then rises until the pixel is transferred.
module line_rasterizer_core #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [lr_pkg::REG_INDEX_BITS-1:0]   cfg_index,
  input  logic [lr_pkg::DIM_BITS-1:0]         cfg_data,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                command,
  input  logic signed [COORD_BITS-1:0]        start_x,
  input  logic signed [COORD_BITS-1:0]        start_y,
  input  logic signed [COORD_BITS-1:0]        end_x,
  input  logic signed [COORD_BITS-1:0]        end_y,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [COORD_BITS-1:0]        pixel_x,
  output logic signed [COORD_BITS-1:0]        pixel_y,
  output logic                                on_canvas,
  output logic                                last_pixel
);
  import lr_pkg::*;

  logic [DIM_BITS-1:0] canvas_width, canvas_height;

  logic in_q_valid;
  cmd_t cmd_q;
  logic signed [COORD_BITS-1:0] start_x_q, start_y_q, end_x_q, end_y_q;

  logic out_free, advance, in_accept;
  logic signed [COORD_BITS-1:0] eng_x, eng_y;
  pixel_flags_t eng_flags;

  assign out_free = !out_valid || !out_stall;
  assign advance = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign in_accept = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      canvas_width <= DIM_BITS'(800);
      canvas_height <= DIM_BITS'(800);
    end else if (cfg_wr_en) begin
      unique case (reg_index_t'(cfg_index))
        REG_CANVAS_WIDTH:  canvas_width <= cfg_data;
        REG_CANVAS_HEIGHT: canvas_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_accept) begin
      in_q_valid <= 1'b1;
    end else if (advance) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      cmd_q <= cmd_t'(command);
      start_x_q <= start_x;
      start_y_q <= start_y;
      end_x_q <= end_x;
      end_y_q <= end_y;
    end
  end

  lr_engine #(
    .COORD_BITS(COORD_BITS)
  ) u_engine (
    .clk           (clk),
    .rst           (rst),
    .go            (advance),
    .cmd           (cmd_q),
    .start_x       (start_x_q),
    .start_y       (start_y_q),
    .end_x         (end_x_q),
    .end_y         (end_y_q),
    .canvas_width  (canvas_width),
    .canvas_height (canvas_height),
    .pixel_x       (eng_x),
    .pixel_y       (eng_y),
    .flags         (eng_flags)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_free) begin
      out_valid <= advance && eng_flags.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (out_free) begin
      pixel_x <= eng_x;
      pixel_y <= eng_y;
      on_canvas <= eng_flags.on_canvas;
      last_pixel <= eng_flags.last_pixel;
    end
  end

endmodule

// File: tb/line_rasterizer_core_tb.sv
`timescale 1ns / 100ps

module line_rasterizer_core_tb;
  import lr_pkg::*;

  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_ITEMS = 145;

  typedef struct packed {
    cmd_t               command;
    logic signed [15:0] sx;
    logic signed [15:0] sy;
    logic signed [15:0] ex;
    logic signed [15:0] ey;
  } line_cmd_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic               on_canvas;
    logic               last_pixel;
  } pixel_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_wr_en = 1'b0;
  logic [REG_INDEX_BITS-1:0] cfg_index = REG_CANVAS_WIDTH;
  logic [DIM_BITS-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic command = CMD_START;
  logic signed [15:0] start_x = '0;
  logic signed [15:0] start_y = '0;
  logic signed [15:0] end_x = '0;
  logic signed [15:0] end_y = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] pixel_x;
  logic signed [15:0] pixel_y;
  logic on_canvas;
  logic last_pixel;

  line_cmd_t pending_cmds[$];
  pixel_t    expected_pixels[$];
  line_cmd_t drv_cmd;
  line_cmd_t seen_cmd;
  pixel_t    seen_px;
  pixel_t    want_px;
  bit        seen_emit;
  bit        calm = 1'b0;
  int        errors = 0;
  int        cycles = 0;

  // line tracker state
  logic signed [15:0] ln_x, ln_y, ln_goal_x, ln_goal_y;
  logic [16:0]        ln_dmaj, ln_dmin;
  logic signed [18:0] ln_err;
  logic               ln_xneg, ln_yneg, ln_steep;
  logic               ln_active = 1'b0;
  logic [DIM_BITS-1:0] canvas_w = 13'd800;
  logic [DIM_BITS-1:0] canvas_h = 13'd800;

  line_rasterizer_core #(.COORD_BITS(16)) u_top (
    .clk(clk),
    .rst(rst),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .command(command),
    .start_x(start_x),
    .start_y(start_y),
    .end_x(end_x),
    .end_y(end_y),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .pixel_x(pixel_x),
    .pixel_y(pixel_y),
    .on_canvas(on_canvas),
    .last_pixel(last_pixel)
  );

  always #5 clk = ~clk;

  task automatic raster_cmd(input line_cmd_t it, output bit emits, output pixel_t px);
    int  dx, dy;
    bit  minor_move;
    emits = 1'b0;
    px = '0;
    if (it.command == CMD_START) begin
      dx = int'(it.ex) - int'(it.sx);
      dy = int'(it.ey) - int'(it.sy);
      if (dx < 0) dx = -dx;
      if (dy < 0) dy = -dy;
      ln_x = it.sx;
      ln_y = it.sy;
      ln_goal_x = it.ex;
      ln_goal_y = it.ey;
      ln_xneg = it.ex < it.sx;
      ln_yneg = it.ey < it.sy;
      ln_steep = dy > dx;
      ln_dmaj = 17'(ln_steep ? dy : dx);
      ln_dmin = 17'(ln_steep ? dx : dy);
      ln_err = 19'(2 * int'(ln_dmin) - int'(ln_dmaj));
      ln_active = 1'b1;
    end else if (ln_active) begin
      emits = 1'b1;
      px.x = ln_x;
      px.y = ln_y;
      px.on_canvas = int'(ln_x) >= 0 && int'(ln_x) < int'(canvas_w) &&
                     int'(ln_y) >= 0 && int'(ln_y) < int'(canvas_h);
      px.last_pixel = ln_steep ? (ln_y == ln_goal_y) : (ln_x == ln_goal_x);
      if (px.last_pixel) begin
        ln_active = 1'b0;
      end else begin
        minor_move = ln_err > 0;
        if (ln_steep || minor_move) ln_y = ln_y + (ln_yneg ? -16'sd1 : 16'sd1);
        if (!ln_steep || minor_move) ln_x = ln_x + (ln_xneg ? -16'sd1 : 16'sd1);
        if (minor_move) ln_err = ln_err - 19'(2 * int'(ln_dmaj));
        ln_err = ln_err + 19'(2 * int'(ln_dmin));
      end
    end
  endtask

  task automatic push_start(input int sx, input int sy, input int ex, input int ey);
    line_cmd_t it;
    it.command = CMD_START;
    it.sx = 16'(sx);
    it.sy = 16'(sy);
    it.ex = 16'(ex);
    it.ey = 16'(ey);
    pending_cmds.push_back(it);
  endtask

  task automatic push_steps(input int n);
    line_cmd_t it;
    repeat (n) begin
      it.command = CMD_STEP;
      it.sx = 16'($urandom);
      it.sy = 16'($urandom);
      it.ex = 16'($urandom);
      it.ey = 16'($urandom);
      pending_cmds.push_back(it);
    end
  endtask

  function automatic int pick_coord(input int dim);
    if ($urandom_range(0, 4) < 3) return int'($urandom_range(0, dim + 40)) - 20;
    return int'($urandom_range(0, 65535)) - 32768;
  endfunction

  function automatic int nudge(input int c, input int reach);
    int d;
    d = ($urandom_range(0, 4) == 0) ? 0 : int'($urandom_range(0, reach));
    if ($urandom_range(0, 1) == 1) d = -d;
    if (c + d > 32767 || c + d < -32768) d = -d;
    return c + d;
  endfunction

  task automatic fill_random(input int quota);
    int made, pick, major, n, sx, sy, ex, ey, ax, ay;
    line_cmd_t it;
    made = 0;
    while (made < quota) begin
      pick = $urandom_range(0, 99);
      if (pick < 80) begin
        sx = pick_coord(int'(canvas_w));
        sy = pick_coord(int'(canvas_h));
        n = ($urandom_range(0, 9) == 0) ? 60 : 12;
        ex = nudge(sx, n);
        ey = nudge(sy, n);
        ax = (ex > sx) ? ex - sx : sx - ex;
        ay = (ey > sy) ? ey - sy : sy - ey;
        major = (ax > ay) ? ax : ay;
        pick = $urandom_range(0, 99);
        if (pick < 70) n = major + 1;
        else if (pick < 85) n = $urandom_range(0, major);
        else n = major + 1 + $urandom_range(1, 3);
        push_start(sx, sy, ex, ey);
        push_steps(n);
        made += 1 + ((n < major + 1) ? n : major + 1);
      end else if (pick < 90) begin
        n = $urandom_range(0, 5);
        push_start(int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768,
                   int'($urandom_range(0, 65535)) - 32768, int'($urandom_range(0, 65535)) - 32768);
        push_steps(n);
        made += 1 + n;
      end else begin
        it.command = cmd_t'($urandom_range(0, 1));
        it.sx = 16'($urandom);
        it.sy = 16'($urandom);
        it.ex = 16'($urandom);
        it.ey = 16'($urandom);
        pending_cmds.push_back(it);
        made++;
      end
    end
  endtask

  task automatic write_canvas(input logic [DIM_BITS-1:0] w, input logic [DIM_BITS-1:0] h);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= REG_CANVAS_WIDTH;
    cfg_data <= w;
    @(posedge clk);
    cfg_index <= REG_CANVAS_HEIGHT;
    cfg_data <= h;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    canvas_w = w;
    canvas_h = h;
  endtask

  // let the block run dry, then cover the start-command latency
  task automatic drain();
    while (pending_cmds.size() != 0 || in_valid || expected_pixels.size() != 0)
      @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (pending_cmds.size() != 0 && (calm || $urandom_range(0, 99) >= 23)) begin
        drv_cmd = pending_cmds.pop_front();
        in_valid <= 1'b1;
        command <= drv_cmd.command;
        start_x <= drv_cmd.sx;
        start_y <= drv_cmd.sy;
        end_x <= drv_cmd.ex;
        end_y <= drv_cmd.ey;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !calm && ($urandom_range(0, 99) < 23);
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_pixels.size() == 0) begin
          $error("pixel transfer with none expected: x=%0d y=%0d", pixel_x, pixel_y);
          errors++;
        end else begin
          want_px = expected_pixels.pop_front();
          if (pixel_x !== want_px.x) begin
            $error("pixel_x expected %0d got %0d", want_px.x, pixel_x);
            errors++;
          end
          if (pixel_y !== want_px.y) begin
            $error("pixel_y expected %0d got %0d", want_px.y, pixel_y);
            errors++;
          end
          if (on_canvas !== want_px.on_canvas) begin
            $error("on_canvas expected %0b got %0b", want_px.on_canvas, on_canvas);
            errors++;
          end
          if (last_pixel !== want_px.last_pixel) begin
            $error("last_pixel expected %0b got %0b", want_px.last_pixel, last_pixel);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        seen_cmd.command = cmd_t'(command);
        seen_cmd.sx = start_x;
        seen_cmd.sy = start_y;
        seen_cmd.ex = end_x;
        seen_cmd.ey = end_y;
        raster_cmd(seen_cmd, seen_emit, seen_px);
        if (seen_emit) expected_pixels.push_back(seen_px);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("line_rasterizer_core_tb: errors");
      $finish;
    end
  end

  initial begin
    int ph;
    logic [DIM_BITS-1:0] phase_w[7];
    logic [DIM_BITS-1:0] phase_h[7];
    phase_w = '{13'd800, 13'd1, 13'd4096, 13'd0, 13'd8191, 13'd0, 13'd64};
    phase_h = '{13'd800, 13'd1, 13'd4096, 13'd8191, 13'd0, 13'd0, 13'd48};
    phase_w[5] = 13'($urandom_range(1, 4096));
    phase_h[5] = 13'($urandom_range(1, 4096));
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // step with no line, single point, full-range diagonals, steep, canvas edge
    push_steps(1);
    push_start(0, 0, 0, 0);
    push_steps(2);
    push_start(-32768, -32768, 32767, 32767);
    push_steps(3);
    push_start(32767, -32768, -32768, 32767);
    push_steps(2);
    push_start(0, 0, 2, -5);
    push_steps(6);
    push_start(798, 799, 801, 799);
    push_steps(4);
    push_start(-1, 2, -1, 0);
    push_steps(2);
    drain();

    for (ph = 0; ph < 7; ph++) begin
      if (ph > 0) write_canvas(phase_w[ph], phase_h[ph]);
      calm = (ph == 2);
      fill_random(PHASE_ITEMS);
      drain();
    end

    repeat (10) @(posedge clk);
    if (errors == 0 && expected_pixels.size() == 0) begin
      $display("line_rasterizer_core_tb: clean");
    end else begin
      $display("line_rasterizer_core_tb: errors");
    end
    $finish;
  end

endmodule
